// ----- rtl/core/nssd_pkg.sv -----
// shared types and constants for the nearest site distance unit
package nssd_pkg;

	localparam int COORD_W  = 16;
	localparam int ACTIVE_W = 7;
	localparam int DIST_W   = 33;
	localparam int ID_W     = 6;
	localparam int T_FRAC_W = 16;
	localparam int PROD_W   = 34;
	localparam int DIFF_W   = 17;

	localparam logic [1:0] MODE_HDR   = 2'd0;
	localparam logic [1:0] MODE_VERT  = 2'd1;
	localparam logic [1:0] MODE_QUERY = 2'd2;

	localparam logic [1:0] KIND_POINT   = 2'd0;
	localparam logic [1:0] KIND_LINE    = 2'd1;
	localparam logic [1:0] KIND_POLY    = 2'd2;
	localparam logic [1:0] KIND_UNKNOWN = 2'd3;

	localparam logic [1:0] TSEL_DIV  = 2'd0;
	localparam logic [1:0] TSEL_ZERO = 2'd1;
	localparam logic [1:0] TSEL_ONE  = 2'd2;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [5:0] site_index;
		logic [3:0] vertex_index;
		logic [1:0] site_kind;
		logic [4:0] vertex_count;
		coord_t     x;
		coord_t     y;
	} nssd_req_t;

	typedef struct packed {
		logic              found;
		logic [ID_W-1:0]   site_id;
		logic [DIST_W-1:0] distance_sq;
	} nssd_rsp_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} point_t;

	typedef struct packed {
		logic signed [DIFF_W-1:0] px;
		logic signed [DIFF_W-1:0] py;
		logic signed [DIFF_W-1:0] vx;
		logic signed [DIFF_W-1:0] vy;
	} geo_t;

	typedef struct packed {
		logic [PROD_W-1:0]   rem;
		logic [PROD_W-1:0]   den;
		logic [T_FRAC_W-1:0] q;
		logic [1:0]          tsel;
		geo_t                geo;
	} div_t;

endpackage

// ----- rtl/core/nssd_if.sv -----
// request and response channel interfaces
interface nssd_req_if;
	import nssd_pkg::*;
	logic      valid;
	logic      ready;
	nssd_req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface nssd_rsp_if;
	import nssd_pkg::*;
	logic      valid;
	logic      ready;
	nssd_rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/nearest_site_segment_distance_unit.sv -----
// top level: site store, query sequencer and nearest site tracker
//
//  channel  dir  handshake            payload
//  req      in   req.valid/req.ready  mode, site_index, vertex_index, site_kind,
//                                     vertex_count, x, y
//  rsp      out  rsp.valid/rsp.ready  found, site_id, distance_sq
//  cfg      in   cfg_we               cfg_wdata (active_sites)
//
// a query walks every searched site, reading its header and then any vertices;
// the single vertex memory read port streams one segment a cycle into the cell chain
// reset clears control state only; the stores hold garbage until written
// a finished result waits in the output register while loads go on; a further
// query stalls only at its end until that result is taken
module nearest_site_segment_distance_unit #(
	parameter int MAX_SITES = 64,
	parameter int MAX_VERTS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [nssd_pkg::ACTIVE_W-1:0]  cfg_wdata,
	nssd_req_if.sink                       req,
	nssd_rsp_if.source                     rsp
);
	import nssd_pkg::*;

	localparam int SITE_W = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
	localparam int N_W    = $clog2(MAX_SITES + 1);
	localparam int VERT_W = $clog2(MAX_VERTS);
	localparam int CNT_W  = $clog2(MAX_VERTS + 1);
	localparam int VA_W   = SITE_W + VERT_W;
	localparam int HDR_W  = 7;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_HDR   = 3'd1;
	localparam logic [2:0] ST_VSET  = 3'd2;
	localparam logic [2:0] ST_VERT  = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]          state_q;
	logic [ACTIVE_W-1:0] active_q;
	logic [N_W-1:0]      site_q, nsites_q;
	logic [CNT_W-1:0]    k_q, cnt_q;
	logic [CNT_W:0]      nreads_q;
	logic                point_q;
	point_t              query_q;

	logic                accept;
	logic [N_W-1:0]      nsites_c;
	logic                last_site;

	logic                hdr_we, hdr_re;
	logic [HDR_W-1:0]    hdr_rd;
	logic [1:0]          kind_c;
	logic [4:0]          cnt_raw;
	logic [CNT_W-1:0]    cnt_c;
	logic [CNT_W:0]      nreads_c;

	logic                vtx_we, vtx_re;
	logic [VA_W-1:0]     vtx_waddr, vtx_raddr;
	point_t              vtx_wd, vtx_rd;

	logic                rv_q, rfirst_q, rpoint_q;
	logic [SITE_W-1:0]   rsite_q;
	point_t              prev_q;

	logic                seg_v;
	point_t              seg_a;
	logic                pv, pipe_busy;
	logic [SITE_W-1:0]   ptag;
	logic [DIST_W-1:0]   pdist;

	logic                have_q;
	logic [DIST_W-1:0]   best_q;
	logic [SITE_W-1:0]   best_site_q;

	logic                out_valid_q;
	nssd_rsp_t           out_q;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid & req.ready;
	assign nsites_c  = (active_q > MAX_SITES) ? N_W'(MAX_SITES) : N_W'(active_q);
	assign last_site = (N_W'(site_q + 1'b1) == nsites_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (cfg_we) begin
			active_q <= cfg_wdata;
		end
	end

	// site header store
	assign hdr_we = accept && (req.data.mode == MODE_HDR)
		&& (32'(req.data.site_index) < MAX_SITES);
	assign hdr_re = (state_q == ST_HDR);

	nssd_ram #(.WIDTH(HDR_W), .DEPTH(MAX_SITES)) u_hdr_ram (
		.clk     (clk),
		.wr_en   (hdr_we),
		.wr_addr (SITE_W'(req.data.site_index)),
		.wr_data ({req.data.site_kind, req.data.vertex_count}),
		.rd_en   (hdr_re),
		.rd_addr (site_q[SITE_W-1:0]),
		.rd_data (hdr_rd)
	);

	always_comb begin
		kind_c  = hdr_rd[HDR_W-1:HDR_W-2];
		cnt_raw = hdr_rd[4:0];
		cnt_c   = (32'(cnt_raw) > MAX_VERTS) ? CNT_W'(MAX_VERTS) : CNT_W'(cnt_raw);
		unique case (kind_c)
			KIND_LINE: nreads_c = (32'(cnt_c) >= 2) ? {1'b0, cnt_c} : '0;
			KIND_POLY: nreads_c = (cnt_c != '0) ? ({1'b0, cnt_c} + 1'b1) : '0;
			default:   nreads_c = (CNT_W+1)'(1);
		endcase
	end

	// vertex store
	assign vtx_we    = accept && (req.data.mode == MODE_VERT)
		&& (32'(req.data.site_index) < MAX_SITES)
		&& (32'(req.data.vertex_index) < MAX_VERTS);
	assign vtx_waddr = {SITE_W'(req.data.site_index), VERT_W'(req.data.vertex_index)};
	assign vtx_wd    = '{x: req.data.x, y: req.data.y};
	assign vtx_re    = (state_q == ST_VERT);
	assign vtx_raddr = {site_q[SITE_W-1:0],
		(k_q == cnt_q) ? {VERT_W{1'b0}} : k_q[VERT_W-1:0]};

	nssd_ram #(.WIDTH(2 * COORD_W), .DEPTH(1 << VA_W)) u_vtx_ram (
		.clk     (clk),
		.wr_en   (vtx_we),
		.wr_addr (vtx_waddr),
		.wr_data (vtx_wd),
		.rd_en   (vtx_re),
		.rd_addr (vtx_raddr),
		.rd_data (vtx_rd)
	);

	// query sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rv_q    <= 1'b0;
		end else begin
			rv_q <= vtx_re;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (req.data.mode == MODE_QUERY)) begin
						state_q <= (nsites_c == '0) ? ST_DRAIN : ST_HDR;
					end
				end
				ST_HDR: begin
					state_q <= ST_VSET;
				end
				ST_VSET: begin
					priority if (nreads_c != '0) begin
						state_q <= ST_VERT;
					end else if (last_site) begin
						state_q <= ST_DRAIN;
					end else begin
						state_q <= ST_HDR;
					end
				end
				ST_VERT: begin
					if ((CNT_W+1)'(k_q + 1'b1) == nreads_q) begin
						state_q <= last_site ? ST_DRAIN : ST_HDR;
					end
				end
				ST_DRAIN: begin
					if (!rv_q && !pipe_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (req.data.mode == MODE_QUERY)) begin
			query_q  <= '{x: req.data.x, y: req.data.y};
			nsites_q <= nsites_c;
			site_q   <= '0;
		end
		if (state_q == ST_VSET) begin
			cnt_q    <= cnt_c;
			nreads_q <= nreads_c;
			point_q  <= (kind_c == KIND_POINT) || (kind_c == KIND_UNKNOWN);
			k_q      <= '0;
			if (nreads_c == '0) begin
				site_q <= N_W'(site_q + 1'b1);
			end
		end
		if (state_q == ST_VERT) begin
			k_q <= CNT_W'(k_q + 1'b1);
			if ((CNT_W+1)'(k_q + 1'b1) == nreads_q) begin
				site_q <= N_W'(site_q + 1'b1);
			end
		end
		rfirst_q <= (k_q == '0);
		rpoint_q <= point_q;
		rsite_q  <= site_q[SITE_W-1:0];
		if (rv_q) begin
			prev_q <= vtx_rd;
		end
	end

	// segment from the previous vertex, a point is a segment of zero length
	assign seg_v = rv_q && (rpoint_q || !rfirst_q);
	assign seg_a = rpoint_q ? vtx_rd : prev_q;

	nssd_seg_pipe #(.TAG_W(SITE_W)) u_seg_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.seg_valid  (seg_v),
		.seg_tag    (rsite_q),
		.seg_a      (seg_a),
		.seg_b      (vtx_rd),
		.query      (query_q),
		.dist_valid (pv),
		.dist_tag   (ptag),
		.dist_sq    (pdist),
		.busy       (pipe_busy)
	);

	// nearest so far, first site wins on ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (accept && (req.data.mode == MODE_QUERY)) begin
			have_q <= 1'b0;
		end else if (pv) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pv && (!have_q || (pdist < best_q))) begin
			best_q      <= pdist;
			best_site_q <= ptag;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && (!out_valid_q || rsp.ready)) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && (!out_valid_q || rsp.ready)) begin
			out_q.found       <= have_q;
			out_q.site_id     <= have_q ? ID_W'(best_site_q) : '0;
			out_q.distance_sq <= have_q ? best_q : '0;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> (!pipe_busy && !rv_q))
		else $error("items in flight while taking requests");

	a_seg_in_query: assert property (@(posedge clk) disable iff (!arst_n)
		seg_v |-> ((state_q == ST_VERT) || (state_q == ST_HDR) || (state_q == ST_VSET)
			|| (state_q == ST_DRAIN)))
		else $error("segment outside a query");

	a_best_falls: assert property (@(posedge clk) disable iff (!arst_n)
		(pv && have_q) |=> (best_q <= $past(best_q)))
		else $error("nearest distance grew");

	a_tag_range: assert property (@(posedge clk) disable iff (!arst_n)
		pv |-> (32'(ptag) < 32'(nsites_q)))
		else $error("distance for a site not searched");
endmodule

// ----- rtl/core/nssd_ram.sv -----
// generic single write port ram with registered read
module nssd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                       clk,
	input  logic                                       wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                           wr_data,
	input  logic                                       rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                           rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

// ----- rtl/core/nssd_div_cell.sv -----
// one restoring division cell, one quotient bit per cell
module nssd_div_cell #(
	parameter int TAG_W = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [TAG_W-1:0]   in_tag,
	input  nssd_pkg::div_t     in_div,
	output logic               out_valid,
	output logic [TAG_W-1:0]   out_tag,
	output nssd_pkg::div_t     out_div
);
	import nssd_pkg::*;

	logic [PROD_W:0] rem2;
	logic [PROD_W:0] den2;
	logic            ge;
	div_t            nxt;

	always_comb begin
		rem2    = {in_div.rem, 1'b0};
		den2    = {1'b0, in_div.den};
		ge      = (rem2 >= den2);
		nxt     = in_div;
		nxt.rem = ge ? PROD_W'(rem2 - den2) : rem2[PROD_W-1:0];
		nxt.q   = {in_div.q[T_FRAC_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_tag <= in_tag;
		out_div <= nxt;
	end
endmodule

// ----- rtl/core/nssd_seg_pipe.sv -----
// segment distance pipeline with a chain of division cells
module nssd_seg_pipe #(
	parameter int TAG_W = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          seg_valid,
	input  logic [TAG_W-1:0]              seg_tag,
	input  nssd_pkg::point_t              seg_a,
	input  nssd_pkg::point_t              seg_b,
	input  nssd_pkg::point_t              query,
	output logic                          dist_valid,
	output logic [TAG_W-1:0]              dist_tag,
	output logic [nssd_pkg::DIST_W-1:0]   dist_sq,
	output logic                          busy
);
	import nssd_pkg::*;

	logic                     v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [TAG_W-1:0]         tag_s1, tag_s2, tag_s4, tag_s5;
	logic signed [DIFF_W-1:0] vx_s1, vy_s1, px_s1, py_s1;
	logic signed [PROD_W-1:0] den_s2, num_s2;
	geo_t                     geo_s2;
	logic signed [PROD_W-1:0] vxx, vyy, vpx, vpy;
	div_t                     div_init;
	logic                     dv_c   [T_FRAC_W+1];
	logic [TAG_W-1:0]         dtag_c [T_FRAC_W+1];
	div_t                     div_c  [T_FRAC_W+1];
	logic [T_FRAC_W:0]        t_val;
	logic signed [PROD_W:0]   prod_x, prod_y;
	logic signed [17:0]       offx_s4, offy_s4;
	logic signed [DIFF_W-1:0] px_s4, py_s4;
	logic signed [17:0]       dxw, dyw;
	logic signed [DIFF_W-1:0] dx_s5, dy_s5;
	logic signed [PROD_W-1:0] dxx, dyy;
	logic                     cells_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
			v_s5       <= 1'b0;
			dist_valid <= 1'b0;
		end else begin
			v_s1       <= seg_valid;
			v_s2       <= v_s1;
			v_s3       <= v_s2;
			v_s4       <= dv_c[T_FRAC_W];
			v_s5       <= v_s4;
			dist_valid <= v_s5;
		end
	end

	// difference vectors
	always_ff @(posedge clk) begin
		tag_s1 <= seg_tag;
		vx_s1  <= {seg_b.x[COORD_W-1], seg_b.x} - {seg_a.x[COORD_W-1], seg_a.x};
		vy_s1  <= {seg_b.y[COORD_W-1], seg_b.y} - {seg_a.y[COORD_W-1], seg_a.y};
		px_s1  <= {query.x[COORD_W-1], query.x} - {seg_a.x[COORD_W-1], seg_a.x};
		py_s1  <= {query.y[COORD_W-1], query.y} - {seg_a.y[COORD_W-1], seg_a.y};
	end

	// squared length and dot product
	always_comb begin
		vxx = vx_s1 * vx_s1;
		vyy = vy_s1 * vy_s1;
		vpx = vx_s1 * px_s1;
		vpy = vy_s1 * py_s1;
	end

	always_ff @(posedge clk) begin
		tag_s2    <= tag_s1;
		den_s2    <= vxx + vyy;
		num_s2    <= vpx + vpy;
		geo_s2.px <= px_s1;
		geo_s2.py <= py_s1;
		geo_s2.vx <= vx_s1;
		geo_s2.vy <= vy_s1;
	end

	// clamp decision and division start
	always_comb begin
		div_init.rem = num_s2;
		div_init.den = den_s2;
		div_init.q   = '0;
		div_init.geo = geo_s2;
		priority if (num_s2 <= 0) begin
			div_init.tsel = TSEL_ZERO;
		end else if (num_s2 >= den_s2) begin
			div_init.tsel = TSEL_ONE;
		end else begin
			div_init.tsel = TSEL_DIV;
		end
	end

	always_ff @(posedge clk) begin
		dtag_c[0] <= tag_s2;
		div_c[0]  <= div_init;
	end

	assign dv_c[0] = v_s3;

	for (genvar i = 0; i < T_FRAC_W; i++) begin : g_cell
		nssd_div_cell #(.TAG_W(TAG_W)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (dv_c[i]),
			.in_tag    (dtag_c[i]),
			.in_div    (div_c[i]),
			.out_valid (dv_c[i+1]),
			.out_tag   (dtag_c[i+1]),
			.out_div   (div_c[i+1])
		);
	end

	// projection offset, rounded half up
	always_comb begin
		unique case (div_c[T_FRAC_W].tsel)
			TSEL_ZERO: t_val = '0;
			TSEL_ONE:  t_val = {1'b1, {T_FRAC_W{1'b0}}};
			default:   t_val = {1'b0, div_c[T_FRAC_W].q};
		endcase
		prod_x = $signed({1'b0, t_val}) * div_c[T_FRAC_W].geo.vx
			+ $signed((PROD_W+1)'(1 << (T_FRAC_W - 1)));
		prod_y = $signed({1'b0, t_val}) * div_c[T_FRAC_W].geo.vy
			+ $signed((PROD_W+1)'(1 << (T_FRAC_W - 1)));
	end

	always_ff @(posedge clk) begin
		tag_s4  <= dtag_c[T_FRAC_W];
		offx_s4 <= 18'(prod_x >>> T_FRAC_W);
		offy_s4 <= 18'(prod_y >>> T_FRAC_W);
		px_s4   <= div_c[T_FRAC_W].geo.px;
		py_s4   <= div_c[T_FRAC_W].geo.py;
	end

	always_comb begin
		dxw = offx_s4 - {px_s4[DIFF_W-1], px_s4};
		dyw = offy_s4 - {py_s4[DIFF_W-1], py_s4};
	end

	always_ff @(posedge clk) begin
		tag_s5 <= tag_s4;
		dx_s5  <= DIFF_W'(dxw);
		dy_s5  <= DIFF_W'(dyw);
	end

	always_comb begin
		dxx = dx_s5 * dx_s5;
		dyy = dy_s5 * dy_s5;
	end

	always_ff @(posedge clk) begin
		dist_tag <= tag_s5;
		dist_sq  <= DIST_W'(dxx + dyy);
	end

	always_comb begin
		cells_busy = 1'b0;
		for (int i = 1; i <= T_FRAC_W; i++) begin
			cells_busy = cells_busy | dv_c[i];
		end
	end

	assign busy = v_s1 | v_s2 | v_s3 | cells_busy | v_s4 | v_s5 | dist_valid;
endmodule

// ----- tb/tb_nearest_site_segment_distance_unit.sv -----
// testbench for the nearest site segment distance unit
`timescale 1ns / 1ps

module tb_nearest_site_segment_distance_unit;
	import nssd_pkg::*;

	localparam logic [1:0] MODE_NOP     = 2'd3;
	localparam int         SITES        = 64;
	localparam int         VERTS        = 16;
	localparam int         HOLD_CYCLES  = 3000;
	localparam int         SETTLE       = 40;

	typedef struct {
		bit          is_cfg;
		logic [6:0]  cfg_val;
		logic [1:0]  mode;
		logic [5:0]  site;
		logic [3:0]  vert;
		logic [1:0]  kind;
		logic [4:0]  cnt;
		int          x;
		int          y;
		bit          typed;
		logic        found;
		logic [5:0]  id;
		logic [32:0] dsq;
	} row_t;

	row_t dir_tab[25] = '{
		'{0, 0, MODE_QUERY, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0},
		'{0, 0, MODE_NOP, 0, 0, KIND_LINE, 3, 7, 7, 0, 0, 0, 0},
		'{0, 0, MODE_VERT, 0, 0, 0, 0, -32768, -32768, 0, 0, 0, 0},
		'{0, 0, MODE_HDR, 0, 0, KIND_POINT, 0, 0, 0, 0, 0, 0, 0},
		'{0, 0, MODE_VERT, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{0, 0, MODE_VERT, 1, 1, 0, 0, 100, 0, 0, 0, 0, 0},
		'{0, 0, MODE_VERT, 1, 2, 0, 0, 100, 100, 0, 0, 0, 0},
		'{0, 0, MODE_HDR, 1, 0, KIND_LINE, 3, 0, 0, 0, 0, 0, 0},
		'{0, 0, MODE_VERT, 2, 0, 0, 0, 10, 10, 0, 0, 0, 0},
		'{0, 0, MODE_VERT, 2, 1, 0, 0, 10, 10, 0, 0, 0, 0},
		'{0, 0, MODE_VERT, 2, 2, 0, 0, 20, 10, 0, 0, 0, 0},
		'{0, 0, MODE_HDR, 2, 0, KIND_POLY, 3, 0, 0, 0, 0, 0, 0},
		'{0, 0, MODE_VERT, 3, 0, 0, 0, 32767, 32767, 0, 0, 0, 0},
		'{0, 0, MODE_HDR, 3, 0, KIND_UNKNOWN, 0, 0, 0, 0, 0, 0, 0},
		'{0, 0, MODE_VERT, 4, 0, 0, 0, 5, 5, 0, 0, 0, 0},
		'{0, 0, MODE_HDR, 4, 0, KIND_LINE, 1, 0, 0, 0, 0, 0, 0},
		'{0, 0, MODE_HDR, 5, 0, KIND_POLY, 0, 0, 0, 0, 0, 0, 0},
		'{0, 0, MODE_QUERY, 0, 0, 0, 0, 32767, 32767, 1, 0, 0, 0},
		'{1, 6, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{0, 0, MODE_QUERY, 0, 0, 0, 0, -32768, -32768, 1, 1, 0, 0},
		'{0, 0, MODE_QUERY, 0, 0, 0, 0, 32767, 32767, 1, 1, 3, 0},
		'{0, 0, MODE_QUERY, 0, 0, 0, 0, 50, -7, 0, 0, 0, 0},
		'{0, 0, MODE_QUERY, 0, 0, 0, 0, 15, 11, 0, 0, 0, 0},
		'{0, 0, MODE_QUERY, 0, 0, 0, 0, -32768, 32767, 0, 0, 0, 0},
		'{0, 0, MODE_QUERY, 0, 0, 0, 0, 101, 50, 0, 0, 0, 0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [ACTIVE_W-1:0] cfg_wdata;

	nssd_req_if req_ch ();
	nssd_rsp_if rsp_ch ();

	nearest_site_segment_distance_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	always #5 clk = ~clk;

	initial begin
		#15ms;
		$display("TB_ERROR");
		$finish;
	end

	// shadow of the block's site store
	logic [1:0] kind_mem [SITES];
	logic [4:0] cnt_mem [SITES];
	coord_t     vx_mem [SITES][VERTS];
	coord_t     vy_mem [SITES][VERTS];
	bit         hdr_done [SITES];
	bit         vert_done [SITES][VERTS];
	int         active_sites;

	nssd_rsp_t  nearest_q [$];
	int         errs;
	int         n_sent;
	int         send_idle;
	int         recv_idle;
	bit         hold_go;
	bit         hold_done;
	int         hold_cnt;

	function automatic longint seg_dist_sq(longint qx, longint qy, longint ax, longint ay,
			longint bx, longint by);
		longint vx, vy, px, py, den, num, t, lx, ly;
		vx = bx - ax;
		vy = by - ay;
		px = qx - ax;
		py = qy - ay;
		den = vx * vx + vy * vy;
		if (den == 0)
			return px * px + py * py;
		num = vx * px + vy * py;
		if (num <= 0)
			t = 0;
		else if (num >= den)
			t = 65536;
		else
			t = (num * 65536) / den;
		lx = ax + ((t * vx + 32768) >>> 16);
		ly = ay + ((t * vy + 32768) >>> 16);
		return (lx - qx) * (lx - qx) + (ly - qy) * (ly - qy);
	endfunction

	function automatic bit site_dist_sq(int s, longint qx, longint qy, output longint d);
		int n, nseg, j;
		longint e;
		bit have;
		have = 0;
		d = 0;
		n = (int'(cnt_mem[s]) > VERTS) ? VERTS : int'(cnt_mem[s]);
		if (kind_mem[s] == KIND_POINT || kind_mem[s] == KIND_UNKNOWN) begin
			d = (qx - vx_mem[s][0]) * (qx - vx_mem[s][0]) +
				(qy - vy_mem[s][0]) * (qy - vy_mem[s][0]);
			return 1;
		end
		nseg = (kind_mem[s] == KIND_LINE) ? ((n >= 2) ? n - 1 : 0) : n;
		for (int i = 0; i < nseg; i++) begin
			j = (i + 1 == n) ? 0 : i + 1;
			e = seg_dist_sq(qx, qy, vx_mem[s][i], vy_mem[s][i], vx_mem[s][j], vy_mem[s][j]);
			if (!have || e < d) begin
				d = e;
				have = 1;
			end
		end
		return have;
	endfunction

	function automatic nssd_rsp_t nearest_site(coord_t qx, coord_t qy);
		nssd_rsp_t r;
		int n;
		longint d, best;
		bit have;
		r = '0;
		have = 0;
		best = 0;
		n = (active_sites > SITES) ? SITES : active_sites;
		for (int s = 0; s < n; s++) begin
			if (site_dist_sq(s, qx, qy, d) && (!have || d < best)) begin
				best = d;
				r.site_id = ID_W'(s);
				have = 1;
			end
		end
		r.found = have;
		r.distance_sq = have ? best[DIST_W-1:0] : '0;
		return r;
	endfunction

	function automatic bit site_safe(int s);
		int n;
		if (!hdr_done[s])
			return 0;
		if (kind_mem[s] == KIND_POINT || kind_mem[s] == KIND_UNKNOWN)
			return vert_done[s][0];
		n = (int'(cnt_mem[s]) > VERTS) ? VERTS : int'(cnt_mem[s]);
		if (kind_mem[s] == KIND_LINE && n < 2)
			return 1;
		for (int i = 0; i < n; i++)
			if (!vert_done[s][i])
				return 0;
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			hold_cnt <= 0;
			hold_done <= 1'b0;
		end else if (hold_go && !hold_done) begin
			rsp_ch.ready <= 1'b0;
			hold_cnt <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_cnt > 0) begin
			rsp_ch.ready <= 1'b0;
			hold_cnt <= hold_cnt - 1;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		nssd_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (nearest_q.size() == 0) begin
				$display("%0t: unexpected item found=%0d site_id=%0d distance_sq=%0d", $time,
					rsp_ch.data.found, rsp_ch.data.site_id, rsp_ch.data.distance_sq);
				errs++;
			end else begin
				want = nearest_q.pop_front();
				if (rsp_ch.data.found !== want.found) begin
					$display("%0t: found expected %0d actual %0d", $time, want.found,
						rsp_ch.data.found);
					errs++;
				end
				if (rsp_ch.data.site_id !== want.site_id) begin
					$display("%0t: site_id expected %0d actual %0d", $time, want.site_id,
						rsp_ch.data.site_id);
					errs++;
				end
				if (rsp_ch.data.distance_sq !== want.distance_sq) begin
					$display("%0t: distance_sq expected %0d actual %0d", $time,
						want.distance_sq, rsp_ch.data.distance_sq);
					errs++;
				end
			end
		end
	end

	task automatic send_item(input nssd_req_t r, input bit typed, input nssd_rsp_t typed_rsp);
		if (n_sent < 200) begin
			send_idle = 8;
			recv_idle = 51;
		end else if (n_sent < 400) begin
			send_idle = 51;
			recv_idle = 8;
		end else begin
			send_idle = 0;
			recv_idle = 0;
		end
		while ($urandom_range(99) < send_idle) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= r;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		n_sent++;
		case (r.mode)
			MODE_HDR: begin
				kind_mem[r.site_index] = r.site_kind;
				cnt_mem[r.site_index] = r.vertex_count;
				hdr_done[r.site_index] = 1;
			end
			MODE_VERT: begin
				vx_mem[r.site_index][r.vertex_index] = r.x;
				vy_mem[r.site_index][r.vertex_index] = r.y;
				vert_done[r.site_index][r.vertex_index] = 1;
			end
			MODE_QUERY: begin
				nearest_q.push_back(typed ? typed_rsp : nearest_site(r.x, r.y));
			end
			default: ;
		endcase
	endtask

	task automatic send(input nssd_req_t r);
		send_item(r, 0, '0);
	endtask

	task automatic write_active(input int v);
		req_ch.valid <= 1'b0;
		while (nearest_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= ACTIVE_W'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		active_sites = v;
	endtask

	function automatic coord_t rand_coord();
		case ($urandom_range(3))
			0: return coord_t'($urandom);
			1: return coord_t'($urandom_range(400) - 200);
			2: case ($urandom_range(3))
				0: return -16'sd32768;
				1: return 16'sd32767;
				2: return 16'sd0;
				default: return -16'sd1;
			endcase
			default: return coord_t'($urandom_range(40) + 1000);
		endcase
	endfunction

	function automatic nssd_req_t rand_req(logic [1:0] m);
		nssd_req_t r;
		r.mode = m;
		r.site_index = 6'($urandom);
		r.vertex_index = 4'($urandom);
		r.site_kind = 2'($urandom);
		r.vertex_count = 5'($urandom);
		r.x = rand_coord();
		r.y = rand_coord();
		return r;
	endfunction

	// vertices first, then the header, so a searched site never reads a blank slot
	task automatic define_site(input int s);
		nssd_req_t r;
		int k, c, nv;
		k = $urandom_range(9);
		r = rand_req(MODE_HDR);
		r.site_index = 6'(s);
		r.site_kind = (k < 3) ? KIND_POINT : (k < 6) ? KIND_LINE : (k < 9) ? KIND_POLY :
			KIND_UNKNOWN;
		c = $urandom_range(19);
		r.vertex_count = 5'((c < 14) ? $urandom_range(5, 1) : (c < 17) ? $urandom_range(1) :
			$urandom_range(31, 16));
		if (r.site_kind == KIND_POINT || r.site_kind == KIND_UNKNOWN)
			nv = 1;
		else
			nv = (int'(r.vertex_count) > VERTS) ? VERTS : int'(r.vertex_count);
		for (int i = 0; i < nv; i++) begin
			nssd_req_t v;
			v = rand_req(MODE_VERT);
			v.site_index = 6'(s);
			v.vertex_index = 4'(i);
			send(v);
		end
		send(r);
	endtask

	task automatic noise_item();
		nssd_req_t r;
		logic [1:0] k;
		logic [4:0] c;
		int pick;
		pick = $urandom_range(2);
		if (pick == 0) begin
			send(rand_req(MODE_VERT));
		end else if (pick == 1) begin
			send(rand_req(MODE_NOP));
		end else begin
			r = rand_req(MODE_HDR);
			k = kind_mem[r.site_index];
			c = cnt_mem[r.site_index];
			kind_mem[r.site_index] = r.site_kind;
			cnt_mem[r.site_index] = r.vertex_count;
			if (!site_safe(r.site_index))
				r.mode = MODE_VERT;
			kind_mem[r.site_index] = k;
			cnt_mem[r.site_index] = c;
			send(r);
		end
	endtask

	task automatic random_phase(input int n_items);
		int start, p;
		start = n_sent;
		while (n_sent - start < n_items) begin
			p = $urandom_range(99);
			if (p < 40)
				send(rand_req(MODE_QUERY));
			else if (p < 75)
				define_site($urandom_range(SITES - 1));
			else
				noise_item();
		end
	endtask

	initial begin
		nssd_req_t r;
		nssd_rsp_t t;
		int lim;
		errs = 0;
		n_sent = 0;
		send_idle = 8;
		recv_idle = 51;
		hold_go = 0;
		active_sites = 0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		foreach (hdr_done[s]) begin
			hdr_done[s] = 0;
			kind_mem[s] = KIND_POINT;
			cnt_mem[s] = '0;
			for (int i = 0; i < VERTS; i++) begin
				vert_done[s][i] = 0;
				vx_mem[s][i] = '0;
				vy_mem[s][i] = '0;
			end
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg) begin
				write_active(dir_tab[i].cfg_val);
			end else begin
				r.mode = dir_tab[i].mode;
				r.site_index = dir_tab[i].site;
				r.vertex_index = dir_tab[i].vert;
				r.site_kind = dir_tab[i].kind;
				r.vertex_count = dir_tab[i].cnt;
				r.x = 16'(dir_tab[i].x);
				r.y = 16'(dir_tab[i].y);
				t.found = dir_tab[i].found;
				t.site_id = dir_tab[i].id;
				t.distance_sq = dir_tab[i].dsq;
				send_item(r, dir_tab[i].typed, t);
			end
		end

		for (int s = 6; s < SITES; s++) begin
			define_site(s);
			if ($urandom_range(2) == 0)
				send(rand_req(MODE_QUERY));
			if ($urandom_range(7) == 0)
				noise_item();
		end

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: write_active(127);
				1: write_active(64);
				2: write_active(0);
				3: write_active(1);
				default: begin
					lim = 0;
					while (lim < SITES && site_safe(lim))
						lim++;
					write_active($urandom_range(lim, 2));
				end
			endcase
			if (ph == 1) begin
				hold_go = 1;
				repeat (8) send(rand_req(MODE_QUERY));
			end
			random_phase(55);
		end

		req_ch.valid <= 1'b0;
		while (nearest_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errs == 0 && nearest_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/nssd_pkg.sv
rtl/core/nssd_if.sv
rtl/core/nssd_ram.sv
rtl/core/nssd_div_cell.sv
rtl/core/nssd_seg_pipe.sv
rtl/core/nearest_site_segment_distance_unit.sv
tb/tb_nearest_site_segment_distance_unit.sv
